// ===== design/vertex_transform_4x4_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Vertex transform assertion macros
// Concurrent checks on clk; they vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_4X4_UNIT_ASSERT_SVH
`define VERTEX_TRANSFORM_4X4_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define VT4_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VT4_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VT4_ASSERT(label, prop, msg)
`define VT4_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== design/vt4_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex transform package
// Widths, matrix register codes and shared types.
// ----------------------------------------------------------------------------
package vt4_pkg;

    localparam int DATA_W            = 32;
    localparam int NUM_COMP          = 4;
    localparam int NUM_REGS          = 8;
    localparam int PROD_W            = 2 * DATA_W;
    localparam int SUM_W             = PROD_W + 2;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 8;
    localparam int FRAC_BITS_DEFAULT = 16;

    typedef logic signed [DATA_W-1:0] elem_t;
    typedef elem_t [NUM_COMP-1:0] vec_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COL0_ROWS01 = 8'd0,
        CFG_COL0_ROWS23 = 8'd1,
        CFG_COL1_ROWS01 = 8'd2,
        CFG_COL1_ROWS23 = 8'd3,
        CFG_COL2_ROWS01 = 8'd4,
        CFG_COL2_ROWS23 = 8'd5,
        CFG_COL3_ROWS01 = 8'd6,
        CFG_COL3_ROWS23 = 8'd7
    } cfg_index_t;

    localparam logic [CFG_DATA_W-1:0] ONE_LOW  = 64'h0000_0000_0001_0000;
    localparam logic [CFG_DATA_W-1:0] ONE_HIGH = 64'h0001_0000_0000_0000;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } pipe_ctrl_t;

endpackage

// ===== design/vertex_transform_4x4_unit.sv =====
// ----------------------------------------------------------------------------
// Vertex transform 4x4 unit
// Multiply each streamed homogeneous vector by a programmable 4x4 matrix.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries input items (x, y, z, w, Q16.16 by default); m_* carries the
//   transformed vector in m_tdata and the clamp flag in m_tuser.
//   cfg_* writes one 64-bit matrix register per handshake; cfg_ready is always
//   high. Indexes beyond the eight matrix registers are dropped.
//   Write the matrix only while no item is in flight.
//   Stages: products register, sum register, then shift and clamp into the
//   output register, whose valid bit drives m_tvalid.
//   Throughput: one item per cycle while m_tready is high; four row lanes of
//   four 32x32 multipliers each work in parallel, so the multiplier stage sets the figure.
//   Stall: when m_tready is low the output register holds; earlier stages
//   keep filling bubbles, and s_tready falls once all three stages are full.
//   Reset: pipeline empties, matrix returns to identity.
// ----------------------------------------------------------------------------
`include "vertex_transform_4x4_unit_assert.svh"

module vertex_transform_4x4_unit #(
    parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [vt4_pkg::NUM_COMP*vt4_pkg::DATA_W-1:0] s_tdata,  // in_x, in_y, in_z, in_w
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [vt4_pkg::NUM_COMP*vt4_pkg::DATA_W-1:0] m_tdata,  // out_x, out_y, out_z, out_w
    output logic [0:0]                             m_tuser,  // saturated
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [vt4_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [vt4_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int DW = vt4_pkg::DATA_W;

    logic [vt4_pkg::CFG_DATA_W-1:0] mat_reg [vt4_pkg::NUM_REGS];
    logic                           v1_reg, v2_reg, v3_reg;
    logic                           v1_next, v2_next, v3_next;
    vt4_pkg::pipe_ctrl_t            ctrl;
    vt4_pkg::vec_t                  vec;
    vt4_pkg::vec_t                  rows [vt4_pkg::NUM_COMP];
    vt4_pkg::vec_t                  comps;
    logic [vt4_pkg::NUM_COMP-1:0]   sats;
    vt4_pkg::vec_t                  result;
    logic                           sat_any;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= vt4_pkg::ONE_LOW;
            mat_reg[1] <= '0;
            mat_reg[2] <= vt4_pkg::ONE_HIGH;
            mat_reg[3] <= '0;
            mat_reg[4] <= '0;
            mat_reg[5] <= vt4_pkg::ONE_LOW;
            mat_reg[6] <= '0;
            mat_reg[7] <= vt4_pkg::ONE_HIGH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                vt4_pkg::CFG_COL0_ROWS01: mat_reg[0] <= cfg_data;
                vt4_pkg::CFG_COL0_ROWS23: mat_reg[1] <= cfg_data;
                vt4_pkg::CFG_COL1_ROWS01: mat_reg[2] <= cfg_data;
                vt4_pkg::CFG_COL1_ROWS23: mat_reg[3] <= cfg_data;
                vt4_pkg::CFG_COL2_ROWS01: mat_reg[4] <= cfg_data;
                vt4_pkg::CFG_COL2_ROWS23: mat_reg[5] <= cfg_data;
                vt4_pkg::CFG_COL3_ROWS01: mat_reg[6] <= cfg_data;
                vt4_pkg::CFG_COL3_ROWS23: mat_reg[7] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int r = 0; r < vt4_pkg::NUM_COMP; r++)
        begin
            for (int c = 0; c < vt4_pkg::NUM_COMP; c++)
            begin
                rows[r][c] = mat_reg[c*2 + r/2][(r%2)*DW +: DW];
            end
        end
        for (int c = 0; c < vt4_pkg::NUM_COMP; c++)
        begin
            vec[c] = s_tdata[c*DW +: DW];
        end
    end

    assign ctrl.en3 = !v3_reg || m_tready;
    assign ctrl.en2 = !v2_reg || ctrl.en3;
    assign ctrl.en1 = !v1_reg || ctrl.en2;
    assign s_tready = ctrl.en1;

    assign v1_next = ctrl.en1 ? s_tvalid : v1_reg;
    assign v2_next = ctrl.en2 ? v1_reg   : v2_reg;
    assign v3_next = ctrl.en3 ? v2_reg   : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    for (genvar r = 0; r < vt4_pkg::NUM_COMP; r++)
    begin : g_lane
        vt4_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .clk  (clk),
            .ctrl (ctrl),
            .row  (rows[r]),
            .vec  (vec),
            .comp (comps[r]),
            .sat  (sats[r])
        );
    end

    vt4_merge u_merge (
        .clk     (clk),
        .ctrl    (ctrl),
        .comps   (comps),
        .sats    (sats),
        .result  (result),
        .sat_any (sat_any)
    );

    assign m_tvalid   = v3_reg;
    assign m_tdata    = result;
    assign m_tuser[0] = sat_any;

    `VT4_ASSERT(a_accept_lands, (s_tvalid && s_tready) |=> v1_reg, "accepted item lost at entry")
    `VT4_ASSERT(a_stage1_holds, (v1_reg && !ctrl.en2) |=> v1_reg, "stalled item dropped in stage one")
    `VT4_ASSERT(a_no_repeat, (m_tvalid && m_tready && !v2_reg) |=> !m_tvalid, "result item repeated")
    `VT4_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "configuration port not ready")

endmodule

// ===== design/vt4_lane.sv =====
// ----------------------------------------------------------------------------
// Vertex transform lane
// One matrix row times the vector: four products, sum, floor shift, clamp.
// ----------------------------------------------------------------------------
module vt4_lane #(
    parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEFAULT
) (
    input  logic               clk,
    input  vt4_pkg::pipe_ctrl_t ctrl,
    input  vt4_pkg::vec_t      row,
    input  vt4_pkg::vec_t      vec,
    output vt4_pkg::elem_t     comp,
    output logic               sat
);

    localparam int SUM_W  = vt4_pkg::SUM_W;
    localparam int PROD_W = vt4_pkg::PROD_W;
    localparam int DATA_W = vt4_pkg::DATA_W;

    logic signed [PROD_W-1:0] prod_reg  [vt4_pkg::NUM_COMP];
    logic signed [PROD_W-1:0] prod_next [vt4_pkg::NUM_COMP];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  shifted;
    logic                     ovf;

    always_comb
    begin
        for (int c = 0; c < vt4_pkg::NUM_COMP; c++)
        begin
            prod_next[c] = PROD_W'($signed(row[c]) * $signed(vec[c]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en1)
        begin
            for (int c = 0; c < vt4_pkg::NUM_COMP; c++)
            begin
                prod_reg[c] <= prod_next[c];
            end
        end
    end

    assign sum_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
                    + SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]);

    always_ff @(posedge clk)
    begin
        if (ctrl.en2)
        begin
            sum_reg <= sum_next;
        end
    end

    assign shifted = sum_reg >>> FRAC_BITS;
    assign ovf = !((&shifted[SUM_W-1:DATA_W-1]) || !(|shifted[SUM_W-1:DATA_W-1]));

    always_comb
    begin
        if (!ovf)
        begin
            comp = shifted[DATA_W-1:0];
        end
        else if (shifted[SUM_W-1])
        begin
            comp = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            comp = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign sat = ovf;

endmodule

// ===== design/vt4_merge.sv =====
// ----------------------------------------------------------------------------
// Vertex transform merge stage
// Collect the lane results into the output register and combine clamp flags.
// ----------------------------------------------------------------------------
module vt4_merge (
    input  logic                clk,
    input  vt4_pkg::pipe_ctrl_t ctrl,
    input  vt4_pkg::vec_t       comps,
    input  logic [vt4_pkg::NUM_COMP-1:0] sats,
    output vt4_pkg::vec_t       result,
    output logic                sat_any
);

    vt4_pkg::vec_t result_reg;
    logic          sat_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en3)
        begin
            result_reg <= comps;
            sat_reg    <= |sats;
        end
    end

    assign result  = result_reg;
    assign sat_any = sat_reg;

endmodule

// ===== tb/vertex_transform_4x4_unit_test.sv =====
// ----------------------------------------------------------------------------
// Vertex transform 4x4 unit testbench
// Streams vectors through the unit under several matrix settings: identity,
// saturating extremes, one-LSB entries with flooring, out-of-range register
// writes and random matrices. A scoreboard predicts each transformed vector
// and checks every output item in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module vertex_transform_4x4_unit_test
    import vt4_pkg::*;
();

    localparam int FRAC          = FRAC_BITS_DEFAULT;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 103;
    localparam int TAIL_CYCLES   = 12;
    localparam int WATCHDOG_MAX  = 2000;

    localparam elem_t ELEM_MAX = 32'sh7FFF_FFFF;
    localparam elem_t ELEM_MIN = 32'sh8000_0000;
    localparam elem_t ONE_Q    = 32'sh0001_0000;

    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    typedef struct {
        vec_t comp;
        logic sat;
    } transformed_t;

    class matrix_transform_model;
        logic [CFG_DATA_W-1:0] matrix_regs [NUM_REGS];
        transformed_t          expected_vectors [$];
        int                    errors;

        function new();
            matrix_regs[CFG_COL0_ROWS01] = ONE_LOW;
            matrix_regs[CFG_COL0_ROWS23] = '0;
            matrix_regs[CFG_COL1_ROWS01] = ONE_HIGH;
            matrix_regs[CFG_COL1_ROWS23] = '0;
            matrix_regs[CFG_COL2_ROWS01] = '0;
            matrix_regs[CFG_COL2_ROWS23] = ONE_LOW;
            matrix_regs[CFG_COL3_ROWS01] = '0;
            matrix_regs[CFG_COL3_ROWS23] = ONE_HIGH;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx < NUM_REGS)
            begin
                matrix_regs[idx] = data;
            end
        endfunction

        function elem_t entry(int row, int col);
            logic [CFG_DATA_W-1:0] word;
            word = matrix_regs[col * 2 + row / 2];
            return (row % 2 == 1) ? elem_t'(word[CFG_DATA_W-1:DATA_W]) : elem_t'(word[DATA_W-1:0]);
        endfunction

        function void note_vector(vec_t v);
            transformed_t             t;
            logic signed [SUM_W-1:0]  acc;
            logic signed [PROD_W-1:0] prod;
            elem_t                    a;
            elem_t                    b;
            t.sat = 1'b0;
            for (int r = 0; r < NUM_COMP; r++)
            begin
                acc = '0;
                for (int c = 0; c < NUM_COMP; c++)
                begin
                    a = entry(r, c);
                    b = v[c];
                    prod = a * b;
                    acc = acc + prod;
                end
                acc = acc >>> FRAC;
                if (acc > SAT_MAX)
                begin
                    t.comp[r] = SAT_MAX[DATA_W-1:0];
                    t.sat = 1'b1;
                end
                else if (acc < SAT_MIN)
                begin
                    t.comp[r] = SAT_MIN[DATA_W-1:0];
                    t.sat = 1'b1;
                end
                else
                begin
                    t.comp[r] = acc[DATA_W-1:0];
                end
            end
            expected_vectors.push_back(t);
        endfunction

        function void check_vector(vec_t got, logic got_sat);
            transformed_t t;
            string        names [NUM_COMP];
            names = '{"x", "y", "z", "w"};
            if (expected_vectors.size() == 0)
            begin
                $display("%0t: unexpected output item %h sat %b", $time, got, got_sat);
                errors++;
                return;
            end
            t = expected_vectors.pop_front();
            for (int r = 0; r < NUM_COMP; r++)
            begin
                if (got[r] !== t.comp[r])
                begin
                    $display("%0t: out_%s expected %h got %h", $time, names[r], t.comp[r], got[r]);
                    errors++;
                end
            end
            if (got_sat !== t.sat)
            begin
                $display("%0t: saturated expected %b got %b", $time, t.sat, got_sat);
                errors++;
            end
        endfunction

        function int pending();
            return expected_vectors.size();
        endfunction
    endclass

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [NUM_COMP*DATA_W-1:0]          s_tdata   = '0;  // in_x, in_y, in_z, in_w
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [NUM_COMP*DATA_W-1:0]          m_tdata;         // out_x, out_y, out_z, out_w
    logic [0:0]                          m_tuser;         // saturated
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [CFG_INDEX_W-1:0]              cfg_index = '0;
    logic [CFG_DATA_W-1:0]               cfg_data  = '0;

    matrix_transform_model board = new();
    logic [CFG_DATA_W-1:0] next_regs [NUM_REGS];
    bit                    quiet_source = 1'b0;
    bit                    quiet_sink   = 1'b0;
    int                    idle_cycles  = 0;

    vertex_transform_4x4_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("vertex_transform_4x4_unit_test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic vec_t make_vec(elem_t x, elem_t y, elem_t z, elem_t w);
        return {w, z, y, x};
    endfunction

    function automatic elem_t pick_extreme();
        case ($urandom_range(0, 6))
            0: return ELEM_MAX;
            1: return ELEM_MIN;
            2: return ONE_Q;
            3: return -ONE_Q;
            4: return 32'sd1;
            5: return -32'sd1;
            default: return '0;
        endcase
    endfunction

    function automatic elem_t rand_component();
        elem_t t;
        case ($urandom_range(0, 3))
            0: t = $urandom;
            1:
            begin
                t = $urandom;
                t = t >>> $urandom_range(0, 31);
            end
            2: t = pick_extreme();
            default:
            begin
                t = $urandom_range(0, 1 << 18);
                t = t - (1 << 17);
            end
        endcase
        return t;
    endfunction

    function automatic elem_t small_entry();
        elem_t t;
        t = $urandom_range(0, 8 << 16);
        return t - (4 << 16);
    endfunction

    function automatic void fill_matrix(logic [CFG_DATA_W-1:0] data);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            next_regs[i] = data;
        end
    endfunction

    function automatic void choose_matrix(int style);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            case (style)
                0: next_regs[i] = {$urandom, $urandom};
                1: next_regs[i] = {small_entry(), small_entry()};
                2: next_regs[i] = {pick_extreme(), pick_extreme()};
                default:
                begin
                    case ($urandom_range(0, 2))
                        0: next_regs[i] = '0;
                        1: next_regs[i] = '1;
                        default: next_regs[i] = {rand_component(), rand_component()};
                    endcase
                end
            endcase
        end
        if (style == 3)
        begin
            next_regs[CFG_COL0_ROWS01] = ONE_LOW;
            next_regs[CFG_COL0_ROWS23] = '0;
            next_regs[CFG_COL1_ROWS01] = ONE_HIGH;
            next_regs[CFG_COL1_ROWS23] = '0;
            next_regs[CFG_COL2_ROWS01] = '0;
            next_regs[CFG_COL2_ROWS23] = ONE_LOW;
            next_regs[CFG_COL3_ROWS01] = {rand_component(), rand_component()};
            next_regs[CFG_COL3_ROWS23] = {ONE_Q, rand_component()};
        end
    endfunction

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.set_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Drop one write to an unmapped index among the real ones.
    task automatic load_matrix();
        int stray;
        stray = $urandom_range(NUM_REGS - 1, 0);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (i == stray)
            begin
                write_register(CFG_INDEX_W'($urandom_range((1 << CFG_INDEX_W) - 1, NUM_REGS)),
                               {$urandom, $urandom});
            end
            write_register(cfg_index_t'(i), next_regs[i]);
        end
    endtask

    task automatic send_vector(input vec_t v);
        int gap;
        gap = quiet_source ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge clk); while (!s_tready);
        board.note_vector(v);
        @(negedge clk);
    endtask

    // Hold the stream until every expected item has come back.
    task automatic drain_stream();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (board.pending() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        int hold;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            hold = quiet_sink ? 0 : $urandom_range(0, 7);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            board.check_vector(vec_t'(m_tdata), m_tuser[0]);
            @(negedge clk);
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // identity after reset
        send_vector(make_vec('0, '0, '0, '0));
        send_vector(make_vec(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
        send_vector(make_vec(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
        send_vector(make_vec(32'sd1, -32'sd1, ONE_Q, -ONE_Q));
        send_vector(make_vec(ELEM_MAX, ELEM_MIN, 32'sh0000_FFFF, 32'shFFFF_0000));
        drain_stream();

        // largest positive entries: clamp high and low
        fill_matrix({ELEM_MAX, ELEM_MAX});
        load_matrix();
        send_vector(make_vec(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
        send_vector(make_vec(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
        send_vector(make_vec('0, '0, '0, '0));
        send_vector(make_vec(32'sd1, '0, '0, '0));
        drain_stream();

        // most negative entries: widest product sum
        fill_matrix({ELEM_MIN, ELEM_MIN});
        load_matrix();
        send_vector(make_vec(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
        send_vector(make_vec(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
        send_vector(make_vec(-32'sd1, '0, '0, '0));
        drain_stream();

        // one-LSB entries: negative sums floor
        fill_matrix({32'sd1, 32'sd1});
        load_matrix();
        send_vector(make_vec(-32'sd1, '0, '0, '0));
        send_vector(make_vec(-32'sd1, -32'sd1, -32'sd1, -32'sd1));
        send_vector(make_vec(32'sd1, '0, '0, '0));
        send_vector(make_vec(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
        drain_stream();

        // unmapped indexes must leave the matrix alone
        write_register(CFG_INDEX_W'(NUM_REGS), '0);
        write_register('1, '0);
        send_vector(make_vec(-32'sd1, ONE_Q, ELEM_MIN, ELEM_MAX));
        drain_stream();

        fill_matrix('1);
        load_matrix();
        send_vector(make_vec(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
        send_vector(make_vec(ELEM_MAX, -32'sd1, ONE_Q, '0));
        drain_stream();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            choose_matrix(p % 5);
            load_matrix();
            quiet_source = (p % 3 == 1);
            quiet_sink   = (p % 4 == 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_vector(make_vec(rand_component(), rand_component(),
                                     rand_component(), rand_component()));
            end
            drain_stream();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0)
        begin
            $display("vertex_transform_4x4_unit_test passed");
        end
        else
        begin
            $display("vertex_transform_4x4_unit_test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/vt4_pkg.sv
design/vt4_lane.sv
design/vt4_merge.sv
design/vertex_transform_4x4_unit.sv
tb/vertex_transform_4x4_unit_test.sv
